// ----- rtl/core/gravor_pkg.sv -----
// shared types, register codes and reset values for the gravity orientation debouncer
package gravor_pkg;

    // axis codes
    localparam logic [2:0] AXIS_POS_X   = 3'd0;
    localparam logic [2:0] AXIS_NEG_X   = 3'd1;
    localparam logic [2:0] AXIS_POS_Y   = 3'd2;
    localparam logic [2:0] AXIS_NEG_Y   = 3'd3;
    localparam logic [2:0] AXIS_UNKNOWN = 3'd4;

    // quarter turn code for an unknown orientation
    localparam logic [2:0] TURNS_UNKNOWN = 3'd4;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 14;

    localparam logic [CFG_ADDR_W-1:0] REG_AXIS_THRESHOLD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DIAG_HYST      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STABLE_TIME    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_POLL_INTERVAL  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ALLOWED_MASK   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SETUP_TURNS    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MOUNT_TURNS    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_AUTO_ENABLE    = 3'd7;

    // reset values: 0.55 g and 0.12 g in 1/4096 g
    localparam logic [12:0] RST_AXIS_THRESHOLD = 13'd2253;
    localparam logic [11:0] RST_DIAG_HYST      = 12'd492;
    localparam logic [13:0] RST_STABLE_TIME    = 14'd600;
    localparam logic [10:0] RST_POLL_INTERVAL  = 11'd100;
    localparam logic [3:0]  RST_ALLOWED_MASK   = 4'hF;
    localparam logic [1:0]  RST_SETUP_TURNS    = 2'd0;
    localparam logic [1:0]  RST_MOUNT_TURNS    = 2'd0;
    localparam logic        RST_AUTO_ENABLE    = 1'b1;

    localparam logic [15:0] ERROR_COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               read_ok;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  effective_turns;
        logic        rotation_changed;
        logic [2:0]  stable_orientation;
        logic [2:0]  stable_axis;
        logic        sample_taken;
        logic [15:0] error_count;
    } out_item_t;

    typedef struct packed {
        logic [12:0] axis_threshold;
        logic [11:0] diagonal_hysteresis;
        logic [13:0] stable_time_ms;
        logic [10:0] poll_interval_ms;
        logic [3:0]  allowed_turns_mask;
        logic [1:0]  setup_turns;
        logic [1:0]  mount_turns;
        logic        auto_enable;
    } cfg_t;

    // classifier verdict for one sample
    typedef struct packed {
        logic [2:0] axis;
        logic [2:0] turns;
    } cls_t;

endpackage

// ----- rtl/core/gravor_classify.sv -----
// dominant axis classification with diagonal hysteresis and turn mapping
module gravor_classify (
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  gravor_pkg::cfg_t   cfg,
    input  logic [2:0]         cand_axis,
    input  logic [2:0]         settled_axis,
    output gravor_pkg::cls_t   cls
);

    logic [16:0] mag_x;
    logic [16:0] mag_y;
    logic [16:0] top;
    logic [16:0] diff;
    logic        x_ge_y;
    logic [2:0]  axis;
    logic [1:0]  raw_turns;
    logic [1:0]  q_turns;
    logic [3:0]  mask;

    always_comb begin
        mag_x  = accel_x[15] ? (17'd0 - {accel_x[15], accel_x}) : {1'b0, accel_x};
        mag_y  = accel_y[15] ? (17'd0 - {accel_y[15], accel_y}) : {1'b0, accel_y};
        x_ge_y = (mag_x >= mag_y);
        top    = x_ge_y ? mag_x : mag_y;
        diff   = x_ge_y ? (mag_x - mag_y) : (mag_y - mag_x);

        if (top < {4'd0, cfg.axis_threshold}) begin
            axis = gravor_pkg::AXIS_UNKNOWN;
        end else if (diff < {5'd0, cfg.diagonal_hysteresis} &&
                     cand_axis != gravor_pkg::AXIS_UNKNOWN) begin
            axis = cand_axis;
        end else if (diff < {5'd0, cfg.diagonal_hysteresis} &&
                     settled_axis != gravor_pkg::AXIS_UNKNOWN) begin
            axis = settled_axis;
        end else if (x_ge_y) begin
            axis = accel_x[15] ? gravor_pkg::AXIS_NEG_X : gravor_pkg::AXIS_POS_X;
        end else begin
            axis = accel_y[15] ? gravor_pkg::AXIS_NEG_Y : gravor_pkg::AXIS_POS_Y;
        end

        // +Y is upright, then clockwise +X, -Y, -X
        case (axis)
            gravor_pkg::AXIS_POS_X: raw_turns = 2'd1;
            gravor_pkg::AXIS_NEG_Y: raw_turns = 2'd2;
            gravor_pkg::AXIS_NEG_X: raw_turns = 2'd3;
            default:                raw_turns = 2'd0;
        endcase

        q_turns = raw_turns - cfg.mount_turns;
        mask    = (cfg.allowed_turns_mask == 4'd0) ? 4'd1 : cfg.allowed_turns_mask;

        cls.axis = axis;
        if (axis == gravor_pkg::AXIS_UNKNOWN || !mask[q_turns]) begin
            cls.turns = gravor_pkg::TURNS_UNKNOWN;
        end else begin
            cls.turns = {1'b0, q_turns};
        end
    end

endmodule

// ----- rtl/core/gravity_orientation_debouncer.sv -----
// top level of the gravity orientation debouncer
//
// Takes timestamped X/Y accelerometer samples (1/4096 g) on the s_ channel and
// returns one result per sample on the m_ channel: effective rotation, change
// flag, stable orientation and axis, interval gate flag and failed read count.
// Samples closer than poll_interval_ms to the last gated one are passed
// through without touching the orientation state.
//
// The result is registered: it sits in the output register the cycle after
// the transaction. Throughput is one sample per cycle while the receiver
// keeps up; the orientation state is updated by the same single combinational
// pass that builds the result, so each sample sees the state left by the
// previous one. When the receiver stalls, the output register holds its result
// and s_ready drops until it is taken; nothing is lost or repeated.
//
// Reset (aresetn low, synchronous) restores all settings to their defaults,
// sets the orientation state to unknown and clears the error count. Register
// writes through cfg_we/cfg_addr/cfg_wdata take effect the next cycle and do
// not clear the orientation state; write them only while the block is idle.
module gravity_orientation_debouncer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  gravor_pkg::in_item_t                  s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output gravor_pkg::out_item_t                 m_data,
    input  logic                                  cfg_we,
    input  logic [gravor_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [gravor_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    gravor_pkg::cfg_t      cfg_reg;
    gravor_pkg::cls_t      cls;
    gravor_pkg::out_item_t m_data_reg;
    gravor_pkg::out_item_t m_data_next;

    logic        m_valid_reg;
    logic [2:0]  cand_axis_reg,     cand_axis_next;
    logic [2:0]  settled_axis_reg,  settled_axis_next;
    logic [2:0]  cand_turns_reg,    cand_turns_next;
    logic [2:0]  settled_turns_reg, settled_turns_next;
    logic [31:0] cand_start_reg,    cand_start_next;
    logic [31:0] last_accept_reg,   last_accept_next;
    logic [15:0] fail_count_reg,    fail_count_next;
    logic [1:0]  last_eff_reg,      last_eff_next;

    logic        accept;
    logic        taken;
    logic [31:0] gate_elapsed;
    logic [31:0] cand_elapsed;
    logic [1:0]  auto_turns;
    logic [1:0]  eff_turns;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    gravor_classify u_classify (
        .accel_x      (s_data.accel_x),
        .accel_y      (s_data.accel_y),
        .cfg          (cfg_reg),
        .cand_axis    (cand_axis_reg),
        .settled_axis (settled_axis_reg),
        .cls          (cls)
    );

    always_comb begin
        cand_axis_next     = cand_axis_reg;
        settled_axis_next  = settled_axis_reg;
        cand_turns_next    = cand_turns_reg;
        settled_turns_next = settled_turns_reg;
        cand_start_next    = cand_start_reg;
        last_accept_next   = last_accept_reg;
        fail_count_next    = fail_count_reg;
        last_eff_next      = last_eff_reg;

        gate_elapsed = s_data.now_ms - last_accept_reg;
        cand_elapsed = s_data.now_ms - cand_start_reg;
        taken = cfg_reg.auto_enable && (gate_elapsed >= {21'd0, cfg_reg.poll_interval_ms});

        if (accept && taken) begin
            last_accept_next = s_data.now_ms;
            if (!s_data.read_ok) begin
                if (fail_count_reg != gravor_pkg::ERROR_COUNT_MAX) begin
                    fail_count_next = fail_count_reg + 16'd1;
                end
            end else if (cls.turns == gravor_pkg::TURNS_UNKNOWN) begin
                cand_axis_next  = gravor_pkg::AXIS_UNKNOWN;
                cand_turns_next = gravor_pkg::TURNS_UNKNOWN;
                cand_start_next = s_data.now_ms;
            end else if (cls.axis != cand_axis_reg || cls.turns != cand_turns_reg) begin
                cand_axis_next  = cls.axis;
                cand_turns_next = cls.turns;
                cand_start_next = s_data.now_ms;
            end else if (cand_turns_reg != settled_turns_reg &&
                         cand_elapsed >= {18'd0, cfg_reg.stable_time_ms}) begin
                settled_axis_next  = cand_axis_reg;
                settled_turns_next = cand_turns_reg;
            end
        end

        if (cfg_reg.auto_enable && settled_turns_next != gravor_pkg::TURNS_UNKNOWN) begin
            auto_turns = settled_turns_next[1:0];
        end else begin
            auto_turns = 2'd0;
        end
        eff_turns = cfg_reg.setup_turns + auto_turns;

        if (accept) begin
            last_eff_next = eff_turns;
        end

        m_data_next.effective_turns    = eff_turns;
        m_data_next.rotation_changed   = (eff_turns != last_eff_reg);
        m_data_next.stable_orientation = settled_turns_next;
        m_data_next.stable_axis        = settled_axis_next;
        m_data_next.sample_taken       = taken;
        m_data_next.error_count        = fail_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.axis_threshold      <= gravor_pkg::RST_AXIS_THRESHOLD;
            cfg_reg.diagonal_hysteresis <= gravor_pkg::RST_DIAG_HYST;
            cfg_reg.stable_time_ms      <= gravor_pkg::RST_STABLE_TIME;
            cfg_reg.poll_interval_ms    <= gravor_pkg::RST_POLL_INTERVAL;
            cfg_reg.allowed_turns_mask  <= gravor_pkg::RST_ALLOWED_MASK;
            cfg_reg.setup_turns         <= gravor_pkg::RST_SETUP_TURNS;
            cfg_reg.mount_turns         <= gravor_pkg::RST_MOUNT_TURNS;
            cfg_reg.auto_enable         <= gravor_pkg::RST_AUTO_ENABLE;
        end else if (cfg_we) begin
            case (cfg_addr)
                gravor_pkg::REG_AXIS_THRESHOLD: cfg_reg.axis_threshold <= cfg_wdata[12:0];
                gravor_pkg::REG_DIAG_HYST:   cfg_reg.diagonal_hysteresis <= cfg_wdata[11:0];
                gravor_pkg::REG_STABLE_TIME:    cfg_reg.stable_time_ms <= cfg_wdata[13:0];
                gravor_pkg::REG_POLL_INTERVAL:  cfg_reg.poll_interval_ms <= cfg_wdata[10:0];
                gravor_pkg::REG_ALLOWED_MASK:   cfg_reg.allowed_turns_mask <= cfg_wdata[3:0];
                gravor_pkg::REG_SETUP_TURNS:    cfg_reg.setup_turns <= cfg_wdata[1:0];
                gravor_pkg::REG_MOUNT_TURNS:    cfg_reg.mount_turns <= cfg_wdata[1:0];
                gravor_pkg::REG_AUTO_ENABLE:    cfg_reg.auto_enable <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg       <= 1'b0;
            cand_axis_reg     <= gravor_pkg::AXIS_UNKNOWN;
            settled_axis_reg  <= gravor_pkg::AXIS_UNKNOWN;
            cand_turns_reg    <= gravor_pkg::TURNS_UNKNOWN;
            settled_turns_reg <= gravor_pkg::TURNS_UNKNOWN;
            cand_start_reg    <= 32'd0;
            last_accept_reg   <= 32'd0;
            fail_count_reg    <= 16'd0;
            last_eff_reg      <= 2'd0;
        end else begin
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            cand_axis_reg     <= cand_axis_next;
            settled_axis_reg  <= settled_axis_next;
            cand_turns_reg    <= cand_turns_next;
            settled_turns_reg <= settled_turns_next;
            cand_start_reg    <= cand_start_next;
            last_accept_reg   <= last_accept_next;
            fail_count_reg    <= fail_count_next;
            last_eff_reg      <= last_eff_next;
        end
    end

    // payload register, loaded on each input transaction
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ----- rtl/core/gravor_checker.sv -----
// port-level assertions for the gravity orientation debouncer, with bind
module gravor_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input gravor_pkg::out_item_t m_data
);

    // a result waiting in the output register is held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled output must block the input side
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    // every input transaction leaves a result behind
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("input transaction produced no result");

    // axis and turns settle together, so both are unknown or both known
    a_settled_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.stable_axis == gravor_pkg::AXIS_UNKNOWN) ==
                     (m_data.stable_orientation == gravor_pkg::TURNS_UNKNOWN)))
        else $error("stable axis and orientation disagree on unknown");

endmodule

bind gravity_orientation_debouncer gravor_checker u_gravor_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- bench/testbench.sv -----
// self-checking testbench for the gravity orientation debouncer
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 800000;

    localparam gravor_pkg::cfg_t CFG_DEFAULT = '{
        axis_threshold:      gravor_pkg::RST_AXIS_THRESHOLD,
        diagonal_hysteresis: gravor_pkg::RST_DIAG_HYST,
        stable_time_ms:      gravor_pkg::RST_STABLE_TIME,
        poll_interval_ms:    gravor_pkg::RST_POLL_INTERVAL,
        allowed_turns_mask:  gravor_pkg::RST_ALLOWED_MASK,
        setup_turns:         gravor_pkg::RST_SETUP_TURNS,
        mount_turns:         gravor_pkg::RST_MOUNT_TURNS,
        auto_enable:         gravor_pkg::RST_AUTO_ENABLE
    };

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    gravor_pkg::in_item_t              s_data = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    gravor_pkg::out_item_t             m_data;
    logic                              cfg_we = 1'b0;
    logic [gravor_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [gravor_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // predicted orientation state
    gravor_pkg::cfg_t active_cfg = CFG_DEFAULT;
    logic [2:0]  cand_axis = gravor_pkg::AXIS_UNKNOWN;
    logic [2:0]  settled_axis = gravor_pkg::AXIS_UNKNOWN;
    logic [2:0]  cand_turns = gravor_pkg::TURNS_UNKNOWN;
    logic [2:0]  settled_turns = gravor_pkg::TURNS_UNKNOWN;
    logic [31:0] cand_start = '0;
    logic [31:0] last_gate = '0;
    logic [15:0] fail_count = '0;
    logic [1:0]  last_eff = '0;

    gravor_pkg::out_item_t orient_expected[$];
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    // stimulus controls
    logic [31:0] sample_clock = '0;
    bit          tx_gaps = 1'b1;
    bit          rx_stalls = 1'b1;
    int          rx_hold_cycles = 0;

    gravity_orientation_debouncer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [2:0] dominant_axis(input logic signed [15:0] x,
                                                 input logic signed [15:0] y);
        int ax, ay, top, diff;
        ax = (x < 0) ? -int'(x) : int'(x);
        ay = (y < 0) ? -int'(y) : int'(y);
        top = (ax > ay) ? ax : ay;
        diff = (ax > ay) ? ax - ay : ay - ax;
        if (top < int'(active_cfg.axis_threshold)) return gravor_pkg::AXIS_UNKNOWN;
        // near the diagonal keep whatever direction we already had
        if (diff < int'(active_cfg.diagonal_hysteresis)) begin
            if (cand_axis != gravor_pkg::AXIS_UNKNOWN) return cand_axis;
            if (settled_axis != gravor_pkg::AXIS_UNKNOWN) return settled_axis;
        end
        if (ax >= ay) return (x >= 0) ? gravor_pkg::AXIS_POS_X : gravor_pkg::AXIS_NEG_X;
        return (y >= 0) ? gravor_pkg::AXIS_POS_Y : gravor_pkg::AXIS_NEG_Y;
    endfunction

    function automatic logic [2:0] axis_to_turns(input logic [2:0] axis);
        logic [1:0] raw, q;
        logic [3:0] mask;
        case (axis)
            gravor_pkg::AXIS_POS_X: raw = 2'd1;
            gravor_pkg::AXIS_NEG_Y: raw = 2'd2;
            gravor_pkg::AXIS_NEG_X: raw = 2'd3;
            default: raw = 2'd0;
        endcase
        q = raw - active_cfg.mount_turns;
        mask = (active_cfg.allowed_turns_mask == 4'd0) ? 4'd1 : active_cfg.allowed_turns_mask;
        return mask[q] ? {1'b0, q} : gravor_pkg::TURNS_UNKNOWN;
    endfunction

    function automatic gravor_pkg::out_item_t predict_orientation(
        input gravor_pkg::in_item_t it);
        logic [2:0]  axis, turns;
        logic [1:0]  auto_q, eff;
        logic [31:0] elapsed;
        gravor_pkg::out_item_t r;
        r = '0;
        elapsed = it.now_ms - last_gate;
        if (active_cfg.auto_enable && elapsed >= 32'(active_cfg.poll_interval_ms)) begin
            r.sample_taken = 1'b1;
            last_gate = it.now_ms;
            if (!it.read_ok) begin
                if (fail_count != gravor_pkg::ERROR_COUNT_MAX) fail_count++;
            end else begin
                axis = dominant_axis(it.accel_x, it.accel_y);
                turns = (axis == gravor_pkg::AXIS_UNKNOWN) ?
                        gravor_pkg::TURNS_UNKNOWN : axis_to_turns(axis);
                elapsed = it.now_ms - cand_start;
                if (turns == gravor_pkg::TURNS_UNKNOWN) begin
                    cand_axis = gravor_pkg::AXIS_UNKNOWN;
                    cand_turns = gravor_pkg::TURNS_UNKNOWN;
                    cand_start = it.now_ms;
                end else if (axis != cand_axis || turns != cand_turns) begin
                    cand_axis = axis;
                    cand_turns = turns;
                    cand_start = it.now_ms;
                end else if (cand_turns != settled_turns &&
                             elapsed >= 32'(active_cfg.stable_time_ms)) begin
                    settled_axis = cand_axis;
                    settled_turns = cand_turns;
                end
            end
        end
        auto_q = (active_cfg.auto_enable && settled_turns != gravor_pkg::TURNS_UNKNOWN) ?
                 settled_turns[1:0] : 2'd0;
        eff = active_cfg.setup_turns + auto_q;
        r.effective_turns = eff;
        r.rotation_changed = (eff != last_eff);
        last_eff = eff;
        r.stable_orientation = settled_turns;
        r.stable_axis = settled_axis;
        r.error_count = fail_count;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // predict on every input transaction, compare on every output transaction
    always @(posedge aclk) begin : scoreboard
        gravor_pkg::out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) orient_expected.push_back(predict_orientation(s_data));
            if (m_valid && m_ready) begin
                results_seen++;
                if (orient_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected, expected none, actual %h",
                             $time, m_data);
                end else begin
                    want = orient_expected.pop_front();
                    check_field("effective_turns", want.effective_turns,
                                m_data.effective_turns);
                    check_field("rotation_changed", want.rotation_changed,
                                m_data.rotation_changed);
                    check_field("stable_orientation", want.stable_orientation,
                                m_data.stable_orientation);
                    check_field("stable_axis", want.stable_axis, m_data.stable_axis);
                    check_field("sample_taken", want.sample_taken, m_data.sample_taken);
                    check_field("error_count", want.error_count, m_data.error_count);
                end
            end
        end
    end

    function automatic int idle_span();
        int r;
        r = int'($urandom_range(0, 19));
        if (r < 16) return int'($urandom_range(1, 3));
        if (r < 19) return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    // receiver side: random stalls, plus a long hold-off on request
    initial begin : result_sink
        int span;
        forever begin
            if (rx_hold_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
                span = idle_span();
                m_ready <= 1'b0;
                repeat (span) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // called at a clock edge; returns after the transaction and any idle gap
    task automatic send_sample(input gravor_pkg::in_item_t it);
        int gap;
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        gap = (tx_gaps && $urandom_range(0, 2) == 0) ? idle_span() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_at(input logic [31:0] now, input bit ok,
                           input int x, input int y);
        gravor_pkg::in_item_t it;
        it.now_ms = now;
        it.read_ok = ok;
        it.accel_x = clip16(x);
        it.accel_y = clip16(y);
        sample_clock = now;
        send_sample(it);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (results_seen != items_sent) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic load_cfg(input gravor_pkg::cfg_t c);
        logic [gravor_pkg::CFG_DATA_W-1:0] vals [8];
        vals[gravor_pkg::REG_AXIS_THRESHOLD] = gravor_pkg::CFG_DATA_W'(c.axis_threshold);
        vals[gravor_pkg::REG_DIAG_HYST]      = gravor_pkg::CFG_DATA_W'(c.diagonal_hysteresis);
        vals[gravor_pkg::REG_STABLE_TIME]    = gravor_pkg::CFG_DATA_W'(c.stable_time_ms);
        vals[gravor_pkg::REG_POLL_INTERVAL]  = gravor_pkg::CFG_DATA_W'(c.poll_interval_ms);
        vals[gravor_pkg::REG_ALLOWED_MASK]   = gravor_pkg::CFG_DATA_W'(c.allowed_turns_mask);
        vals[gravor_pkg::REG_SETUP_TURNS]    = gravor_pkg::CFG_DATA_W'(c.setup_turns);
        vals[gravor_pkg::REG_MOUNT_TURNS]    = gravor_pkg::CFG_DATA_W'(c.mount_turns);
        vals[gravor_pkg::REG_AUTO_ENABLE]    = gravor_pkg::CFG_DATA_W'(c.auto_enable);
        for (int i = 0; i < 8; i++) begin
            cfg_we <= 1'b1;
            cfg_addr <= gravor_pkg::CFG_ADDR_W'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        active_cfg = c;
        @(posedge aclk);
    endtask

    function automatic logic signed [15:0] clip16(input int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic int flip(input int v);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // pose: 0..3 one axis dominant, 4 near diagonal, 5 weak, else raw noise
    function automatic gravor_pkg::in_item_t random_reading(input int pose);
        int thr, hyst, major, minor, a, b;
        gravor_pkg::in_item_t it;
        it = '0;
        thr = int'(active_cfg.axis_threshold);
        hyst = int'(active_cfg.diagonal_hysteresis);
        it.read_ok = ($urandom_range(0, 15) != 0);
        major = thr - 150 + int'($urandom_range(0, 4200));
        if (major < 0) major = 0;
        minor = flip(int'($urandom_range(0, major / 2)));
        case (pose)
            0: begin it.accel_x = clip16(major);  it.accel_y = clip16(minor); end
            1: begin it.accel_x = clip16(-major); it.accel_y = clip16(minor); end
            2: begin it.accel_y = clip16(major);  it.accel_x = clip16(minor); end
            3: begin it.accel_y = clip16(-major); it.accel_x = clip16(minor); end
            4: begin
                a = int'($urandom_range(1000, 9000));
                b = a - (hyst + 40) + int'($urandom_range(0, 2 * hyst + 80));
                it.accel_x = clip16(flip(a));
                it.accel_y = clip16(flip(b));
            end
            5: begin
                it.accel_x = clip16(flip(int'($urandom_range(0, thr))));
                it.accel_y = clip16(flip(int'($urandom_range(0, thr))));
            end
            default: begin
                it.accel_x = 16'($urandom);
                it.accel_y = 16'($urandom);
            end
        endcase
        return it;
    endfunction

    // counted is set when the reading should pass the gate or auto_enable is off
    task automatic send_reading(input int pose, output bit counted);
        gravor_pkg::in_item_t it;
        int r;
        it = random_reading(pose);
        r = $urandom_range(0, 19);
        if (r == 0)
            sample_clock = $urandom;
        else if (r < 3)
            sample_clock += $urandom_range(0, active_cfg.poll_interval_ms);
        else
            sample_clock += active_cfg.poll_interval_ms +
                $urandom_range(0, active_cfg.stable_time_ms / 4 + active_cfg.poll_interval_ms);
        it.now_ms = sample_clock;
        counted = (r >= 3) || !active_cfg.auto_enable;
        send_sample(it);
    endtask

    task automatic run_phase(input gravor_pkg::cfg_t c, input int n);
        int  done_n, pose, hold, r;
        bit  counted;
        drain();
        load_cfg(c);
        done_n = 0;
        while (done_n < n) begin
            r = $urandom_range(0, 9);
            pose = (r < 7) ? r % 4 : r - 3;
            hold = $urandom_range(1, 14);
            tx_gaps = ($urandom_range(0, 5) != 0);
            rx_stalls = tx_gaps;
            repeat (hold) begin
                send_reading(pose, counted);
                if (counted) done_n++;
            end
        end
    endtask

    task automatic test_basic_orientation();
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        send_at(0, 1, 4096, 0);                 // too soon after reset, ignored
        send_at(100, 1, 4096, 0);
        send_at(699, 1, 4096, 0);               // one ms short of settling
        send_at(799, 1, 4096, 0);
        send_at(850, 1, -4096, 0);              // inside the poll window
        send_at(900, 0, 0, 0);                  // failed read
        send_at(1000, 1, -32768, 0);
        send_at(1100, 1, 3000, -2800);          // diagonal keeps candidate
        send_at(1600, 1, -32768, 32767);        // settles exactly at stable time
        send_at(1700, 1, 2252, 0);              // just under threshold
        send_at(1800, 1, 2253, 0);              // exactly at threshold
        send_at(1900, 1, 0, 32767);
        send_at(2000, 1, 1000, 1492);           // difference equals the band
        send_at(2500, 1, 0, 32767);
        send_at(2600, 1, -100, -32768);
        send_at(3200, 1, -32768, -32768);
        send_at(32'hffff_ff80, 1, 0, -4096);
        send_at(32'h0000_0010, 1, 32767, 0);    // timestamp wrap
        send_at(32'h0000_0050, 0, 1, -1);
    endtask

    task automatic test_register_cases();
        gravor_pkg::cfg_t c;
        c = CFG_DEFAULT;
        c.allowed_turns_mask = 4'd0;            // empty mask allows zero turns only
        c.mount_turns = 2'd1;
        c.setup_turns = 2'd1;
        drain();
        load_cfg(c);
        send_at(sample_clock + 100, 1, 0, 8000);
        send_at(sample_clock + 100, 1, 8000, 0);
        send_at(sample_clock + 700, 1, 8000, 0);
        c.auto_enable = 1'b0;
        c.setup_turns = 2'd2;
        drain();
        load_cfg(c);
        send_at(sample_clock + 100, 1, 0, -8000);
        send_at(sample_clock + 900, 0, 0, -8000);
    endtask

    task automatic test_random_traffic();
        gravor_pkg::cfg_t c;
        run_phase(CFG_DEFAULT, 180);
        c = '{axis_threshold: 13'd410, diagonal_hysteresis: 12'd2048,
              stable_time_ms: 14'd0, poll_interval_ms: 11'd20,
              allowed_turns_mask: 4'b0101, setup_turns: 2'd3,
              mount_turns: 2'd1, auto_enable: 1'b1};
        run_phase(c, 170);
        c = '{axis_threshold: 13'd6144, diagonal_hysteresis: 12'd0,
              stable_time_ms: 14'd10000, poll_interval_ms: 11'd2000,
              allowed_turns_mask: 4'b0000, setup_turns: 2'd2,
              mount_turns: 2'd3, auto_enable: 1'b1};
        run_phase(c, 170);
        c = '{axis_threshold: 13'h1fff, diagonal_hysteresis: 12'hfff,
              stable_time_ms: 14'h3fff, poll_interval_ms: 11'd0,
              allowed_turns_mask: 4'b1010, setup_turns: 2'd1,
              mount_turns: 2'd2, auto_enable: 1'b1};
        run_phase(c, 170);
        c = '{axis_threshold: 13'd0, diagonal_hysteresis: 12'd100,
              stable_time_ms: 14'd1, poll_interval_ms: 11'h7ff,
              allowed_turns_mask: 4'b1111, setup_turns: 2'd0,
              mount_turns: 2'd0, auto_enable: 1'b1};
        run_phase(c, 100);
        c.auto_enable = 1'b0;
        c.setup_turns = 2'd3;
        run_phase(c, 40);
    endtask

    // output held off long enough for the input to back up
    task automatic test_backpressure();
        bit counted;
        drain();
        load_cfg(CFG_DEFAULT);
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        rx_hold_cycles = 300;
        repeat (24) send_reading($urandom_range(0, 4), counted);
    endtask

    // a burst of mostly failed reads, every one past the gate
    task automatic test_failed_reads();
        gravor_pkg::cfg_t     c;
        gravor_pkg::in_item_t it;
        c = CFG_DEFAULT;
        c.poll_interval_ms = 11'd0;
        drain();
        load_cfg(c);
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        repeat (32) begin
            it.now_ms = $urandom;
            it.read_ok = ($urandom_range(0, 3) == 0);
            it.accel_x = 16'($urandom);
            it.accel_y = 16'($urandom);
            send_sample(it);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_orientation();
        test_register_cases();
        test_random_traffic();
        test_backpressure();
        test_failed_reads();
        drain();
        repeat (5) @(posedge aclk);
        if (mismatches == 0 && orient_expected.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
